// File: src/bmp2rgb_pkg.sv
// ----------------------------------------------------------------------------
// bmp2rgb_pkg
// shared constants, types and a colour helper for the bmp pixel converter
// ----------------------------------------------------------------------------
package bmp2rgb_pkg;

	localparam int PaletteBits = 8;
	localparam int WidthBits   = 12;

	localparam int PalDepth = 1 << PaletteBits;
	localparam int ColW     = WidthBits + 1;
	localparam int RowW     = WidthBits + 2;
	localparam int BitsW    = ColW + 5;

	localparam logic [ColW-1:0] WidthMax = ColW'(1 << WidthBits);

	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 13;
	localparam int DepthW   = 5;

	localparam logic [CfgIdxW-1:0] RegBitDepth   = 2'd0;
	localparam logic [CfgIdxW-1:0] RegIs565      = 2'd1;
	localparam logic [CfgIdxW-1:0] RegImageWidth = 2'd2;
	localparam logic [CfgIdxW-1:0] RegCropWidth  = 2'd3;

	localparam logic [DepthW-1:0] Depth1  = 5'd1;
	localparam logic [DepthW-1:0] Depth4  = 5'd4;
	localparam logic [DepthW-1:0] Depth8  = 5'd8;
	localparam logic [DepthW-1:0] Depth16 = 5'd16;
	localparam logic [DepthW-1:0] Depth24 = 5'd24;

	typedef struct packed {
		logic [DepthW-1:0] depth;
		logic              is_565;
		logic [ColW-1:0]   iw;
		logic [ColW-1:0]   cw;
		logic [RowW-1:0]   row_size;
		logic              supported;
		logic              restart;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		logic        pal;
		logic [15:0] color;
		logic        last;
		logic        row_end;
	} pix_t;

	function automatic logic [15:0] bgr_to_565(input logic [23:0] bgr);
		return {bgr[23:19], bgr[15:10], bgr[7:3]};
	endfunction

endpackage

// File: src/bmp_pixel_to_rgb565.sv
// ----------------------------------------------------------------------------
// bmp_pixel_to_rgb565
// converts bmp pixel-data bytes into rgb565 pixels, with row cropping
// ----------------------------------------------------------------------------
// Takes palette loads and pixel-data bytes in file order and returns
// registered RGB565 pixels. Palette loads and 16/24-bit bytes are taken at
// one per cycle unless the output stalls. A 1-, 4- or 8-bit palette byte
// holds the input for each pixel it emits (up to eight for 1-bit images),
// since every pixel is one read of the single palette RAM port; slots past
// the crop are skipped together. Only the first crop_width pixels of each
// row are returned and padding is consumed silently. Any configuration write
// restarts the row position; write it only while no request is in flight.
// ----------------------------------------------------------------------------
module bmp_pixel_to_rgb565
	import bmp2rgb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                mode,
	input  logic [7:0]          palette_index,
	input  logic [23:0]         palette_bgr,
	input  logic [7:0]          data_byte,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [15:0]         pixel_color,
	output logic                last_of_run,
	output logic                row_end
);

	cfg_t                   cfg;
	pix_t                   pix;
	logic                   adv;
	logic                   rd_en;
	logic [PaletteBits-1:0] rd_addr;
	logic                   wr_en;
	logic [PaletteBits-1:0] wr_addr;
	logic [15:0]            wr_data;
	logic [15:0]            rd_data;

	bmp2rgb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bmp2rgb_unpack u_unpack (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.palette_index (palette_index),
		.palette_bgr   (palette_bgr),
		.data_byte     (data_byte),
		.adv           (adv),
		.pix           (pix),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data)
	);

	bmp2rgb_ram #(
		.Width (16),
		.Depth (PalDepth)
	) u_palette (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	bmp2rgb_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix         (pix),
		.rd_data     (rd_data),
		.adv         (adv),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_color (pixel_color),
		.last_of_run (last_of_run),
		.row_end     (row_end)
	);

endmodule

// File: src/bmp2rgb_ram.sv
// ----------------------------------------------------------------------------
// bmp2rgb_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bmp2rgb_ram #(
	parameter int Width = 16,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0]         rd_data
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: src/bmp2rgb_cfg.sv
// ----------------------------------------------------------------------------
// bmp2rgb_cfg
// configuration registers and the row geometry derived from them
// ----------------------------------------------------------------------------
module bmp2rgb_cfg
	import bmp2rgb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output cfg_t                cfg
);

	logic [DepthW-1:0]   depth_q;
	logic                is565_q;
	logic [CfgDataW-1:0] img_w_q;
	logic [CfgDataW-1:0] crop_w_q;

	logic [ColW-1:0]     iw_q;
	logic [ColW-1:0]     cw_q;
	logic [RowW-1:0]     row_size_q;
	logic                supported_q;

	logic [15:0]         iw_wide;
	logic [15:0]         cw_wide;
	logic [15:0]         iw_sat;
	logic [15:0]         cw_sat;
	logic [ColW-1:0]     iw_eff;
	logic [ColW-1:0]     cw_eff;
	logic [BitsW-1:0]    row_bits;
	logic [BitsW-1:0]    row_bytes;
	logic [BitsW-1:0]    row_padded;
	logic                supported;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= Depth24;
			is565_q  <= 1'b0;
			img_w_q  <= 13'd480;
			crop_w_q <= 13'd480;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				RegBitDepth:   depth_q  <= cfg_data[DepthW-1:0];
				RegIs565:      is565_q  <= cfg_data[0];
				RegImageWidth: img_w_q  <= cfg_data;
				RegCropWidth:  crop_w_q <= cfg_data;
				default:       depth_q  <= depth_q;
			endcase
		end
	end

	// saturate to the maximum width, zero image width counts as one, crop width is limited to the image width
	always_comb begin
		iw_wide = 16'(img_w_q);
		cw_wide = 16'(crop_w_q);
		iw_sat  = (iw_wide > 16'(WidthMax)) ? 16'(WidthMax) : iw_wide;
		cw_sat  = (cw_wide > 16'(WidthMax)) ? 16'(WidthMax) : cw_wide;
		iw_eff  = (iw_sat == 16'd0) ? ColW'(1) : iw_sat[ColW-1:0];
		cw_eff  = (cw_sat[ColW-1:0] > iw_eff) ? iw_eff : cw_sat[ColW-1:0];
	end

	always_comb begin
		case (depth_q)
			Depth1:  row_bits = BitsW'(iw_eff);
			Depth4:  row_bits = BitsW'(iw_eff) << 2;
			Depth8:  row_bits = BitsW'(iw_eff) << 3;
			Depth16: row_bits = BitsW'(iw_eff) << 4;
			Depth24: row_bits = (BitsW'(iw_eff) << 4) + (BitsW'(iw_eff) << 3);
			default: row_bits = '0;
		endcase
		row_bytes  = (row_bits + BitsW'(7)) >> 3;
		row_padded = (row_bytes + BitsW'(3)) & ~BitsW'(3);
		supported  = (depth_q == Depth16) || (depth_q == Depth24) ||
			((depth_q == Depth1) && (PaletteBits >= 1)) ||
			((depth_q == Depth4) && (PaletteBits >= 4)) ||
			((depth_q == Depth8) && (PaletteBits >= 8));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iw_q        <= '0;
			cw_q        <= '0;
			row_size_q  <= '0;
			supported_q <= 1'b0;
		end else begin
			iw_q        <= iw_eff;
			cw_q        <= cw_eff;
			row_size_q  <= row_padded[RowW-1:0];
			supported_q <= supported;
		end
	end

	assign cfg.depth     = depth_q;
	assign cfg.is_565    = is565_q;
	assign cfg.iw        = iw_q;
	assign cfg.cw        = cw_q;
	assign cfg.row_size  = row_size_q;
	assign cfg.supported = supported_q;
	assign cfg.restart   = cfg_wr_en;

endmodule

// File: src/bmp2rgb_unpack.sv
// ----------------------------------------------------------------------------
// bmp2rgb_unpack
// input register, row position tracking and per-pixel decode of each byte
// ----------------------------------------------------------------------------
module bmp2rgb_unpack
	import bmp2rgb_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   mode,
	input  logic [7:0]             palette_index,
	input  logic [23:0]            palette_bgr,
	input  logic [7:0]             data_byte,
	input  logic                   adv,
	output pix_t                   pix,
	output logic                   rd_en,
	output logic [PaletteBits-1:0] rd_addr,
	output logic                   wr_en,
	output logic [PaletteBits-1:0] wr_addr,
	output logic [15:0]            wr_data
);

	logic                   v_s1;
	logic                   mode_s1;
	logic [PaletteBits-1:0] pidx_s1;
	logic [15:0]            pcol_s1;
	logic [7:0]             byte_s1;
	logic [2:0]             slot_q;

	logic [ColW-1:0]        col_q;
	logic [RowW-1:0]        rbc_q;
	logic [15:0]            pend_q;
	logic [1:0]             pcnt_q;

	logic                   acc;
	logic                   step;
	logic                   done;
	logic                   is_pal;
	logic                   pix_step;
	logic                   col_lt_iw;
	logic                   emit_ok;
	logic [ColW-1:0]        col_inc;
	logic                   need_more;
	logic [2:0]             per_last;
	logic [3:0]             rem;
	logic [ColW:0]          col_sum;
	logic [ColW-1:0]        col_jump;
	logic [7:0]             idx;
	logic [15:0]            direct_color;
	logic [RowW-1:0]        rbc_inc;
	logic [ColW-1:0]        col_d;
	logic [15:0]            pend_d;
	logic [1:0]             pcnt_d;
	logic                   row_done;

	assign step     = v_s1 && adv;
	assign in_stall = v_s1 && !(step && done);
	assign acc      = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (step && done) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			mode_s1 <= mode;
			pidx_s1 <= palette_index[PaletteBits-1:0];
			pcol_s1 <= bgr_to_565(palette_bgr);
			byte_s1 <= data_byte;
		end
	end

	// decode of the byte at the current slot
	always_comb begin
		is_pal    = cfg.depth < Depth16;
		pix_step  = step && mode_s1 && cfg.supported;
		col_lt_iw = col_q < cfg.iw;
		emit_ok   = col_q < cfg.cw;
		col_inc   = col_q + ColW'(1);
		need_more = (cfg.depth == Depth24) ? (pcnt_q < 2'd2) : (pcnt_q == 2'd0);

		case (cfg.depth)
			Depth1:  per_last = 3'd7;
			Depth4:  per_last = 3'd1;
			default: per_last = 3'd0;
		endcase
		rem      = 4'(per_last - slot_q) + 4'd1;
		col_sum  = {1'b0, col_q} + (ColW+1)'(rem);
		col_jump = (col_sum > {1'b0, cfg.iw}) ? cfg.iw : col_sum[ColW-1:0];

		case (cfg.depth)
			Depth1:  idx = {7'd0, byte_s1[~slot_q]};
			Depth4:  idx = slot_q[0] ? {4'd0, byte_s1[3:0]} : {4'd0, byte_s1[7:4]};
			default: idx = byte_s1;
		endcase

		if (cfg.depth == Depth24) begin
			direct_color = {byte_s1[7:3], pend_q[7:2], pend_q[15:11]};
		end else if (cfg.is_565) begin
			direct_color = {byte_s1, pend_q[7:0]};
		end else begin
			direct_color = {byte_s1[6:0], pend_q[7:5], 1'b0, pend_q[4:0]};
		end
	end

	// next row state and the pixel request for this step
	always_comb begin
		done        = 1'b1;
		col_d       = col_q;
		pend_d      = pend_q;
		pcnt_d      = pcnt_q;
		pix.valid   = 1'b0;
		pix.pal     = is_pal;
		pix.color   = direct_color;
		pix.last    = 1'b1;
		pix.row_end = col_inc == cfg.cw;
		if (mode_s1 && cfg.supported) begin
			if (!is_pal) begin
				if (col_lt_iw) begin
					if (need_more) begin
						pend_d = {pend_q[7:0], byte_s1};
						pcnt_d = pcnt_q + 2'd1;
					end else begin
						pix.valid = emit_ok;
						col_d     = col_inc;
						pend_d    = '0;
						pcnt_d    = '0;
					end
				end
			end else if (!emit_ok) begin
				col_d = col_jump;
			end else begin
				pix.valid = 1'b1;
				pix.last  = (slot_q == per_last) || (col_inc == cfg.cw);
				col_d     = col_inc;
				done      = (slot_q == per_last) || (col_inc == cfg.iw);
			end
		end
		pix.valid = pix.valid && step;
	end

	assign rbc_inc  = rbc_q + RowW'(1);
	assign row_done = rbc_inc >= cfg.row_size;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			rbc_q  <= '0;
			pend_q <= '0;
			pcnt_q <= '0;
		end else if (cfg.restart) begin
			col_q  <= '0;
			rbc_q  <= '0;
			pend_q <= '0;
			pcnt_q <= '0;
		end else if (pix_step) begin
			if (done && row_done) begin
				col_q  <= '0;
				rbc_q  <= '0;
				pend_q <= '0;
				pcnt_q <= '0;
			end else begin
				col_q  <= col_d;
				pend_q <= pend_d;
				pcnt_q <= pcnt_d;
				if (done) begin
					rbc_q <= rbc_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (step) begin
			slot_q <= done ? 3'd0 : slot_q + 3'd1;
		end
	end

	assign rd_en   = pix.valid && is_pal;
	assign rd_addr = idx[PaletteBits-1:0];
	assign wr_en   = step && !mode_s1;
	assign wr_addr = pidx_s1;
	assign wr_data = pcol_s1;

endmodule

// File: src/bmp2rgb_out.sv
// ----------------------------------------------------------------------------
// bmp2rgb_out
// result register, selects palette read data or direct colour
// ----------------------------------------------------------------------------
module bmp2rgb_out
	import bmp2rgb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  pix_t        pix,
	input  logic [15:0] rd_data,
	output logic        adv,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] pixel_color,
	output logic        last_of_run,
	output logic        row_end
);

	logic        valid_s2;
	logic        pal_s2;
	logic [15:0] color_s2;
	logic        last_s2;
	logic        row_end_s2;

	assign adv = !valid_s2 || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && pix.valid) begin
			pal_s2     <= pix.pal;
			color_s2   <= pix.color;
			last_s2    <= pix.last;
			row_end_s2 <= pix.row_end;
		end
	end

	// palette read data holds while the request waits
	assign out_valid   = valid_s2;
	assign pixel_color = pal_s2 ? rd_data : color_s2;
	assign last_of_run = last_s2;
	assign row_end     = row_end_s2;

endmodule

// File: src/bmp2rgb_chk.sv
// ----------------------------------------------------------------------------
// bmp2rgb_chk
// port-level checks on the converter, bound to the top level
// ----------------------------------------------------------------------------
module bmp2rgb_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] pixel_color,
	input logic        last_of_run,
	input logic        row_end
);

	// a held result request keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_color) &&
			$stable(last_of_run) && $stable(row_end))
		else $error("result changed while stalled");

	// the last pixel of a row is always the last one of its byte
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && row_end |-> last_of_run)
		else $error("row end without last of run");

	// with nothing taken and no stall, the input stays open
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_valid && !in_stall |=> !in_stall)
		else $error("input stalled with no request held");

endmodule

bind bmp_pixel_to_rgb565 bmp2rgb_chk u_chk (.*);

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench for bmp_pixel_to_rgb565
// ----------------------------------------------------------------------------
// Loads palette entries and streams pixel-data bytes through the converter at
// every supported depth, with unsupported depths, cropping, zero and
// saturated widths and row padding. A scoreboard class keeps its own copy of
// the palette, registers and row position, predicts each RGB565 pixel on
// input acceptance and compares the returned pixels in order. The run goes
// through phases with no idling, a gappy sender, a stalling receiver and
// both, plus one long receiver hold-off and a full drain mid-stream.
// ----------------------------------------------------------------------------
module testbench;
	import bmp2rgb_pkg::*;

	localparam int CycleLimit = 400000;

	typedef struct packed {
		logic [15:0] color;
		logic        last;
		logic        row_end;
	} rgb_pixel_t;

	class pixel_scoreboard;
		logic [15:0]      palette[PalDepth];
		bit               written[PalDepth];
		logic [DepthW-1:0] depth;
		bit               is565;
		logic [12:0]      img_w;
		logic [12:0]      crop_w;
		int unsigned      row_bytes, col, pend_bytes, pend_cnt;
		rgb_pixel_t       expected_pixels[$];
		int               mismatches, checked;

		function new();
			depth = Depth24;
			is565 = 1'b0;
			img_w = 13'd480;
			crop_w = 13'd480;
			mismatches = 0;
			checked = 0;
			restart_row();
		endfunction

		function void restart_row();
			row_bytes = 0;
			col = 0;
			pend_bytes = 0;
			pend_cnt = 0;
		endfunction

		function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
			case (idx)
				RegBitDepth: depth = val[DepthW-1:0];
				RegIs565: is565 = val[0];
				RegImageWidth: img_w = val;
				RegCropWidth: crop_w = val;
				default: ;
			endcase
			restart_row();
		endfunction

		function bit supported();
			return depth == Depth16 || depth == Depth24 ||
				((depth == Depth1 || depth == Depth4 || depth == Depth8) &&
				depth <= PaletteBits);
		endfunction

		function int unsigned eff_image_width();
			int unsigned w;
			w = (img_w > WidthMax) ? WidthMax : img_w;
			return (w == 0) ? 1 : w;
		endfunction

		function int unsigned eff_crop_width();
			int unsigned w;
			w = (crop_w > WidthMax) ? WidthMax : crop_w;
			return (w > eff_image_width()) ? eff_image_width() : w;
		endfunction

		function int unsigned row_size();
			return (((eff_image_width() * depth + 7) >> 3) + 3) & ~32'd3;
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction

		function void note_request(bit m, logic [7:0] idx, logic [23:0] bgr, logic [7:0] b);
			int unsigned iw, cw, d, per, msk, sh, pi, need, n;
			logic [7:0] r, g, bl, hi, lo;
			rgb_pixel_t px;
			if (!m) begin
				palette[idx] = {bgr[23:19], bgr[15:10], bgr[7:3]};
				written[idx] = 1;
				return;
			end
			if (!supported())
				return;
			iw = eff_image_width();
			cw = eff_crop_width();
			d = depth;
			n = 0;
			if (d >= 16) begin
				need = d / 8;
				if (col < iw) begin
					if (pend_cnt + 1 < need) begin
						pend_bytes = ((pend_bytes << 8) | b) & 16'hFFFF;
						pend_cnt++;
					end else begin
						if (d == 24) begin
							bl = pend_bytes[15:8];
							g = pend_bytes[7:0];
							r = b;
							px.color = {r[7:3], g[7:2], bl[7:3]};
						end else begin
							lo = pend_bytes[7:0];
							hi = b;
							px.color = is565 ? {hi, lo} : {hi[6:0], lo[7:5], 1'b0, lo[4:0]};
						end
						if (col < cw) begin
							px.last = 1;
							px.row_end = (col + 1 == cw);
							expected_pixels.push_back(px);
						end
						col++;
						pend_bytes = 0;
						pend_cnt = 0;
					end
				end
			end else begin
				per = 8 / d;
				msk = (1 << d) - 1;
				for (int k = 0; k < per && col < iw; k++) begin
					sh = 8 - d * (k + 1);
					pi = (int'(b) >> sh) & msk;
					if (col < cw) begin
						px.color = palette[pi];
						px.last = 0;
						px.row_end = (col + 1 == cw);
						expected_pixels.push_back(px);
						n++;
					end
					col++;
				end
				if (n > 0)
					expected_pixels[expected_pixels.size() - 1].last = 1;
			end
			row_bytes++;
			if (row_bytes >= row_size())
				restart_row();
		endfunction

		function void check_pixel(logic [15:0] c, logic l, logic re);
			rgb_pixel_t exp_px;
			checked++;
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected pixel: colour %h last %b row_end %b", c, l, re);
				return;
			end
			exp_px = expected_pixels.pop_front();
			if (exp_px.color !== c || exp_px.last !== l || exp_px.row_end !== re) begin
				mismatches++;
				if (mismatches <= 10)
					$display("pixel mismatch: expected %h/%b/%b, got %h/%b/%b",
						exp_px.color, exp_px.last, exp_px.row_end, c, l, re);
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                mode = 1'b0;
	logic [7:0]          palette_index = '0;
	logic [23:0]         palette_bgr = '0;
	logic [7:0]          data_byte = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [15:0]         pixel_color;
	logic                last_of_run;
	logic                row_end;

	pixel_scoreboard sb = new();

	int tx_pct = 0;
	int rx_pct = 0;
	int hold_token = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int cycle_count = 0;
	int requests_sent = 0;
	int counted_items = 0;
	int reg_writes = 0;

	bmp_pixel_to_rgb565 i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.palette_index(palette_index),
		.palette_bgr  (palette_bgr),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_color  (pixel_color),
		.last_of_run  (last_of_run),
		.row_end      (row_end)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off when asked
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_token) begin
			hold_seen <= hold_token;
			hold_left <= 300;
			out_stall <= 1'b1;
		end else begin
			out_stall <= (rx_pct > 0) && ($urandom_range(99) < rx_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_pixel(pixel_color, last_of_run, row_end);
	end

	task automatic send_request(input bit m, input logic [7:0] idx, input logic [23:0] bgr,
		input logic [7:0] b);
		while (tx_pct > 0 && $urandom_range(99) < tx_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		palette_index <= idx;
		palette_bgr <= bgr;
		data_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (!m || sb.supported())
			counted_items++;
		sb.note_request(m, idx, bgr, b);
		requests_sent++;
	endtask

	task automatic load_palette(input logic [7:0] idx, input logic [23:0] bgr);
		send_request(1'b0, idx, bgr, 8'($urandom));
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_request(1'b1, 8'($urandom), 24'($urandom), b);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.write_reg(idx, val);
		reg_writes++;
	endtask

	task automatic set_format(input logic [DepthW-1:0] d, input bit is565,
		input logic [CfgDataW-1:0] iw, input logic [CfgDataW-1:0] cw);
		write_reg(RegBitDepth, CfgDataW'(d));
		write_reg(RegIs565, CfgDataW'(is565));
		write_reg(RegImageWidth, iw);
		write_reg(RegCropWidth, cw);
	endtask

	// 8-bit pixels only index entries that were loaded
	function automatic logic [7:0] pick_byte();
		logic [7:0] b;
		b = 8'($urandom);
		if (sb.depth == Depth8) begin
			while (!sb.written[b])
				b = 8'($urandom);
		end
		return b;
	endfunction

	task automatic send_rows(input int nbytes, input int pal_pct);
		for (int i = 0; i < nbytes; i++) begin
			if ($urandom_range(99) < pal_pct)
				load_palette(8'($urandom), 24'($urandom));
			else
				send_byte(pick_byte());
		end
	endtask

	task automatic random_section();
		logic [DepthW-1:0] odd_depths[6];
		logic [DepthW-1:0] d;
		logic [CfgDataW-1:0] iw, cw;
		int r, nbytes;
		odd_depths = '{5'd0, 5'd2, 5'd3, 5'd5, 5'd12, 5'd31};
		r = $urandom_range(99);
		if (r < 18) d = Depth1;
		else if (r < 36) d = Depth4;
		else if (r < 54) d = Depth8;
		else if (r < 72) d = Depth16;
		else if (r < 93) d = Depth24;
		else d = odd_depths[$urandom_range(5)];
		r = $urandom_range(99);
		if (r < 3) iw = 13'd8191;
		else if (r < 6) iw = 13'($urandom_range(8190, 4096));
		else if (r < 9) iw = 13'd0;
		else iw = 13'($urandom_range(24, 1));
		r = $urandom_range(99);
		if (r < 10) cw = 13'd0;
		else if (r < 20) cw = 13'($urandom);
		else cw = 13'($urandom_range(iw + 2));
		set_format(d, 1'($urandom_range(1)), iw, cw);
		nbytes = sb.row_size() * $urandom_range(2, 1);
		if (nbytes > 48)
			nbytes = $urandom_range(48, 8);
		if ($urandom_range(99) < 15)
			nbytes = $urandom_range(nbytes, 1);
		if (!sb.supported())
			nbytes = $urandom_range(4, 1);
		send_rows(nbytes, 10);
	endtask

	task automatic random_phase(input int tx, input int rx, input int quota);
		int start;
		start = counted_items;
		wait_drained();
		tx_pct = tx;
		rx_pct = rx;
		while (counted_items - start < quota)
			random_section();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// 24-bit at reset settings
		send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
		send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);
		// 16-bit 555 then 565
		write_reg(RegBitDepth, CfgDataW'(Depth16));
		send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h5A); send_byte(8'hA5);
		write_reg(RegIs565, 13'd1);
		send_byte(8'hFF); send_byte(8'h7F);
		load_palette(8'd0, 24'h000000);
		load_palette(8'd1, 24'hFFFFFF);
		load_palette(8'd255, 24'h5A3CC3);
		// 1-bit, crop inside row, slots past image width and padding
		set_format(Depth1, 1'b0, 13'd10, 13'd4);
		send_byte(8'hA5); send_byte(8'h5A); send_byte(8'hFF); send_byte(8'h00);
		// zero crop still consumes the row
		write_reg(RegCropWidth, 13'd0);
		send_byte(8'hFF); send_byte(8'h81);
		// crop wider than image, 8-bit
		set_format(Depth8, 1'b0, 13'd2, 13'd8191);
		send_byte(8'hFF); send_byte(8'h01); send_byte(8'h00); send_byte(8'h00);
		// unsupported depth ignores bytes
		write_reg(RegBitDepth, 13'd2);
		send_byte(8'h55); send_byte(8'hAA);
		// zero image width, then saturated widths
		set_format(Depth24, 1'b0, 13'd0, 13'd1);
		send_byte(8'h11); send_byte(8'h22); send_byte(8'h33); send_byte(8'h44);
		set_format(Depth16, 1'b1, 13'd8191, 13'd8191);
		send_byte(8'h00); send_byte(8'h80); send_byte(8'h12);

		// fill the low entries so 1- and 4-bit bytes only read loaded entries
		for (int i = 2; i < 16; i++)
			load_palette(8'(i), 24'($urandom));
		repeat (30)
			load_palette(8'($urandom), 24'($urandom));

		random_phase(0, 0, 30);
		// long receiver hold-off while 1-bit bytes keep coming
		set_format(Depth1, 1'b0, 13'd64, 13'd64);
		hold_token <= hold_token + 1;
		send_rows(40, 0);
		random_phase(48, 0, 30);
		random_phase(0, 48, 30);
		tx_pct = 37;
		rx_pct = 37;
		set_format(Depth4, 1'b0, 13'd20, 13'd17);
		send_rows(20, 10);
		wait_drained();
		send_rows(20, 10);
		random_phase(37, 37, 30);

		wait_drained();
		repeat (20) @(posedge clk);
		$display("%0d requests accepted, %0d pixels checked, %0d register writes",
			requests_sent, sb.checked, reg_writes);
		$display("depths 1/4/8/16/24 and unsupported, crops, padding, four idle mixes");
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("%0d mismatches, %0d pixels outstanding", sb.mismatches, sb.pending());
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

// File: sim.f
src/bmp2rgb_pkg.sv
src/bmp2rgb_ram.sv
src/bmp2rgb_cfg.sv
src/bmp2rgb_unpack.sv
src/bmp2rgb_out.sv
src/bmp_pixel_to_rgb565.sv
src/bmp2rgb_chk.sv
tb/sv/testbench.sv
